// File: hdl/bse_pkg.sv
// box spline evaluation: shared constants, register indexes and control types
// no dependencies
`default_nettype none

package bse_pkg;

    localparam int MAX_DIRECTIONS = 4;
    localparam int FRAC_BITS      = 32;
    localparam int VAL_W          = 48;
    localparam int WID_W          = 41;
    localparam int POS_W          = VAL_W + 1;
    localparam int DVD_W          = VAL_W + FRAC_BITS;
    localparam int ACC_W          = 2 * VAL_W;
    localparam int DIG_W          = 16;
    localparam int CFG_IDX_W      = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIRS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_OFS   = 3'd5;

    typedef struct packed {
        logic load;
        logic pos_step;
        logic leaf_init;
        logic mul_start;
        logic mul_step;
        logic div_leaf;
        logic div_comb;
        logic div_step;
        logic leaf_q;
        logic comb_init;
        logic push;
        logic comb_q;
        logic out_load;
    } bse_cmd_t;

    typedef struct packed {
        logic pos_done;
        logic n_zero;
        logic mul_last;
        logic div_last;
        logic comb_top;
        logic bit_zero;
        logic out_free;
    } bse_stat_t;

endpackage

`default_nettype wire

// File: hdl/bse_div.sv
// restoring divider, one quotient bit per cycle while step is high
// depends on bse_pkg
`default_nettype none

module bse_div
    import bse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic             step,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [WID_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic                  last
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [WID_W-1:0] rem_reg, rem_next;
    logic [WID_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WID_W:0]   trial;
    logic [WID_W:0]   shifted;

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg, dvd_reg[DVD_W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        if (load)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNT_W'(DVD_W - 1);
        end
        else if (step)
        begin
            if (!trial[WID_W])
            begin
                rem_next = trial[WID_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WID_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dvd_reg;
    assign last     = (cnt_reg == '0);

endmodule

`default_nettype wire

// File: hdl/bse_dpath.sv
// datapath: config registers, leaf power loop, difference stack and result register
// depends on bse_pkg and bse_div
`default_nettype none

module bse_dpath
    import bse_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WID_W-1:0]     cfg_data,
    input  wire logic [VAL_W-1:0]     position,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic      [VAL_W-1:0]     spline_value,
    output logic                      overflow_flag,
    input  wire bse_cmd_t             cmd,
    output bse_stat_t                 stat
);

    logic [2:0]       nd_reg;
    logic [WID_W-1:0] w_reg [MAX_DIRECTIONS];
    logic [2:0]       off_reg;

    logic [VAL_W-1:0] x_reg;
    logic [WID_W-1:0] wa_reg [MAX_DIRECTIONS];
    logic [WID_W-1:0] wa_c   [MAX_DIRECTIONS];
    logic [2:0]       m_reg, m_c, kk;
    logic [3:0]       ord_reg, ord_c;
    logic [3:0]       idx_reg;
    logic [2:0]       lvl_reg;
    logic [2:0]       clvl_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] r_reg;
    logic [2:0]       n_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [1:0]       dig_reg;
    logic [VAL_W-1:0] slot_reg [MAX_DIRECTIONS];
    logic             neg_reg;
    logic             ovf_reg;
    logic             ov_reg;
    logic [VAL_W-1:0] ov_val_reg;
    logic             ov_flag_reg;

    logic [2:0]       bsel;
    logic [2:0]       bcomb;
    logic [2:0]       cm1;
    logic [POS_W-1:0] hpos;
    logic [DIG_W-1:0] digit;
    logic [DIG_W+VAL_W-2:0] prod;
    logic [VAL_W:0]   diff;
    logic [VAL_W-1:0] mag;
    logic [DVD_W-1:0] dvd;
    logic [WID_W-1:0] dsr;
    logic [DVD_W-1:0] quot;
    logic             dlast;
    logic [VAL_W-1:0] qlim;
    logic             qsat;

    always_comb
    begin
        kk  = (nd_reg > 3'(MAX_DIRECTIONS)) ? 3'(MAX_DIRECTIONS) : nd_reg;
        m_c = '0;
        for (int j = 0; j < MAX_DIRECTIONS; j++)
        begin
            wa_c[j] = '0;
        end
        for (int j = 0; j < MAX_DIRECTIONS; j++)
        begin
            if ((3'(j) < kk) && (w_reg[j] != '0))
            begin
                wa_c[m_c[1:0]] = w_reg[j];
                m_c = m_c + 3'd1;
            end
        end
        ord_c = {off_reg[2], off_reg} + {1'b0, m_c};
    end

    assign bsel  = m_reg - 3'd1 - lvl_reg;
    assign bcomb = m_reg - clvl_reg;
    assign cm1   = clvl_reg - 3'd1;
    assign hpos  = {{(POS_W-WID_W+1){1'b0}}, wa_reg[lvl_reg[1:0]][WID_W-1:1]};

    always_comb
    begin
        case (dig_reg)
            2'd2:    digit = pos_reg[47:32];
            2'd1:    digit = pos_reg[31:16];
            default: digit = pos_reg[15:0];
        endcase
    end
    assign prod = r_reg[VAL_W-2:0] * digit;

    assign diff = {slot_reg[cm1[1:0]][VAL_W-1], slot_reg[cm1[1:0]]} - {r_reg[VAL_W-1], r_reg};
    assign mag  = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];

    always_comb
    begin
        if (cmd.div_comb)
        begin
            dvd = {mag, {FRAC_BITS{1'b0}}};
            dsr = wa_reg[cm1[1:0]];
        end
        else
        begin
            dvd = {{(DVD_W-64){1'b0}}, acc_reg[FRAC_BITS+63:FRAC_BITS]};
            dsr = {{(WID_W-3){1'b0}}, n_reg};
        end
    end

    bse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_leaf | cmd.div_comb),
        .step     (cmd.div_step),
        .dividend (dvd),
        .divisor  (dsr),
        .quotient (quot),
        .last     (dlast)
    );

    always_comb
    begin
        if (neg_reg)
        begin
            qsat = (quot > DVD_W'(VAL_MAX) + 1'b1);
            qlim = qsat ? (VAL_MAX + 1'b1) : quot[VAL_W-1:0];
        end
        else
        begin
            qsat = (quot > DVD_W'(VAL_MAX));
            qlim = qsat ? VAL_MAX : quot[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg  <= '0;
            off_reg <= '0;
            for (int j = 0; j < MAX_DIRECTIONS; j++)
            begin
                w_reg[j] <= '0;
            end
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_NUM_DIRS:    nd_reg   <= cfg_data[2:0];
                    REG_WIDTH_ZERO:  w_reg[0] <= cfg_data;
                    REG_WIDTH_ONE:   w_reg[1] <= cfg_data;
                    REG_WIDTH_TWO:   w_reg[2] <= cfg_data;
                    REG_WIDTH_THREE: w_reg[3] <= cfg_data;
                    REG_ORDER_OFS:   off_reg  <= cfg_data[2:0];
                    default:         ;
                endcase
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= position;
            m_reg   <= m_c;
            ord_reg <= ord_c;
            idx_reg <= '0;
            lvl_reg <= '0;
            pos_reg <= {position[VAL_W-1], position};
            ovf_reg <= 1'b0;
            for (int j = 0; j < MAX_DIRECTIONS; j++)
            begin
                wa_reg[j] <= wa_c[j];
            end
        end
        if (cmd.pos_step)
        begin
            pos_reg <= idx_reg[bsel[1:0]] ? (pos_reg - hpos) : (pos_reg + hpos);
            lvl_reg <= lvl_reg + 3'd1;
        end
        if (cmd.leaf_init)
        begin
            if (ord_reg[3] || pos_reg[POS_W-1])
            begin
                r_reg <= '0;
                n_reg <= '0;
            end
            else
            begin
                r_reg <= VAL_ONE;
                n_reg <= ord_reg[2:0];
            end
        end
        if (cmd.mul_start)
        begin
            acc_reg <= '0;
            dig_reg <= 2'd2;
        end
        if (cmd.mul_step)
        begin
            acc_reg <= {acc_reg[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}} + ACC_W'(prod);
            dig_reg <= dig_reg - 2'd1;
        end
        if (cmd.leaf_q)
        begin
            if (quot > DVD_W'(VAL_MAX))
            begin
                r_reg   <= VAL_MAX;
                ovf_reg <= 1'b1;
            end
            else
            begin
                r_reg <= quot[VAL_W-1:0];
            end
            n_reg <= n_reg - 3'd1;
        end
        if (cmd.comb_init)
        begin
            clvl_reg <= m_reg;
        end
        if (cmd.push)
        begin
            slot_reg[cm1[1:0]] <= r_reg;
            idx_reg <= idx_reg + 4'd1;
            pos_reg <= {x_reg[VAL_W-1], x_reg};
            lvl_reg <= '0;
        end
        if (cmd.div_comb)
        begin
            neg_reg <= diff[VAL_W];
        end
        if (cmd.comb_q)
        begin
            r_reg    <= neg_reg ? VAL_W'(-qlim) : qlim;
            clvl_reg <= cm1;
            if (qsat)
            begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            ov_val_reg  <= r_reg;
            ov_flag_reg <= ovf_reg;
        end
    end

    assign stat.pos_done = (lvl_reg == m_reg);
    assign stat.n_zero   = (n_reg == '0);
    assign stat.mul_last = (dig_reg == 2'd0);
    assign stat.div_last = dlast;
    assign stat.comb_top = (clvl_reg == '0);
    assign stat.bit_zero = !idx_reg[bcomb[1:0]];
    assign stat.out_free = !ov_reg || out_ready;

    assign out_valid     = ov_reg;
    assign spline_value  = ov_val_reg;
    assign overflow_flag = ov_flag_reg;

endmodule

`default_nettype wire

// File: hdl/bse_ctrl.sv
// controller: sequences leaf positions, power steps, divisions and the difference stack
// depends on bse_pkg
`default_nettype none

module bse_ctrl
    import bse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire bse_stat_t stat,
    output bse_cmd_t       cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_POS   = 11'b00000000010,
        S_LEAF  = 11'b00000000100,
        S_MUL   = 11'b00000001000,
        S_DLOAD = 11'b00000010000,
        S_DIVL  = 11'b00000100000,
        S_LDONE = 11'b00001000000,
        S_COMB  = 11'b00010000000,
        S_DIVC  = 11'b00100000000,
        S_CDONE = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                if (stat.pos_done)
                begin
                    cmd.leaf_init = 1'b1;
                    state_next    = S_LEAF;
                end
                else
                begin
                    cmd.pos_step = 1'b1;
                end
            end
            S_LEAF:
            begin
                if (stat.n_zero)
                begin
                    cmd.comb_init = 1'b1;
                    state_next    = S_COMB;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_leaf = 1'b1;
                state_next   = S_DIVL;
            end
            S_DIVL:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_LDONE;
                end
            end
            S_LDONE:
            begin
                cmd.leaf_q = 1'b1;
                state_next = S_LEAF;
            end
            S_COMB:
            begin
                if (stat.comb_top)
                begin
                    state_next = S_FIN;
                end
                else if (stat.bit_zero)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_POS;
                end
                else
                begin
                    cmd.div_comb = 1'b1;
                    state_next   = S_DIVC;
                end
            end
            S_DIVC:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_CDONE;
                end
            end
            S_CDONE:
            begin
                cmd.comb_q = 1'b1;
                state_next = S_COMB;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/box_spline_evaluation.sv
// each input walks the 2^m leaves, where m is the number of nonzero widths in use and n the
// leaf order (zero for a negative position or order): per leaf, m position steps and n powers,
// each one multiply and one division; then 2^m - 1 width divisions, each with one push; all
// divisions use the 80-bit restoring divider, one quotient bit a cycle
// throughput: one transaction at a time; the next input is taken while a result waits
// reset: rst_n asynchronous active low, clears config registers, controller and output valid
`default_nettype none

module box_spline_evaluation
    import bse_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WID_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [VAL_W-1:0]     s_tdata,  // position
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [VAL_W-1:0]     m_tdata,  // spline_value
    output logic                      m_tuser   // overflow_flag
);

    bse_cmd_t  cmd;
    bse_stat_t stat;

    bse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bse_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .position      (s_tdata),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .spline_value  (m_tdata),
        .overflow_flag (m_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire

// File: hdl/bse_checker.sv
// port checker for box_spline_evaluation, attached by bind
// depends on bse_pkg
`default_nettype none

module bse_checker
    import bse_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [VAL_W-1:0] m_tdata,
    input wire logic             m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after accept");

endmodule

bind box_spline_evaluation bse_checker u_bse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: dv/tb_box_spline_evaluation.sv
// testbench for box_spline_evaluation: directed and random positions under many width settings
// predicts each spline value with its own divided-difference model; needs hdl/bse_pkg.sv
`default_nettype none

module tb_box_spline_evaluation;
    import bse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned SAT_POS = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [WID_W-1:0] WIDTH_MAX = 41'h100_0000_0000;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             flag;
    } spline_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WID_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VAL_W-1:0]     s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [VAL_W-1:0]     m_tdata;
    logic                 m_tuser;

    spline_result_t   pending_results[$];
    int               error_count = 0;
    int               items_sent = 0;
    int               ready_hold = 0;
    bit               sat_seen;
    logic [2:0]       num_dirs_reg = '0;
    logic [WID_W-1:0] width_reg[4] = '{default: '0};
    logic [2:0]       order_ofs_reg = '0;

    box_spline_evaluation u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #100ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // truncated power x^n/n! with saturating steps
    function automatic longint power_leaf(longint x, int ord);
        bit [127:0]      prod;
        longint unsigned r;
        longint unsigned q;
        if (x < 0 || ord < 0)
            return 0;
        r = 64'd1 << FRAC_BITS;
        for (int n = ord; n > 0; n--)
        begin
            prod = {64'd0, r} * {64'd0, x};
            if ((prod >> (64 + FRAC_BITS)) != 0)
            begin
                r = SAT_POS;
                sat_seen = 1'b1;
            end
            else
            begin
                q = prod[FRAC_BITS +: 64] / longint'(n);
                if (q > SAT_POS)
                begin
                    r = SAT_POS;
                    sat_seen = 1'b1;
                end
                else
                    r = q;
            end
        end
        return longint'(r);
    endfunction

    function automatic longint centred_difference(int d, int k, longint x, int ord);
        longint          a;
        longint          b;
        longint          diff;
        longint unsigned w;
        longint unsigned h;
        longint unsigned mag;
        longint unsigned bound;
        bit [127:0]      quot;
        bit              neg;
        if (d >= k)
            return power_leaf(x, ord);
        w = width_reg[d];
        if (w == 0)
            return centred_difference(d + 1, k, x, ord);
        h = w >> 1;
        a = centred_difference(d + 1, k, x + longint'(h), ord + 1);
        b = centred_difference(d + 1, k, x - longint'(h), ord + 1);
        diff = a - b;
        neg = diff < 0;
        mag = neg ? longint'(-diff) : longint'(diff);
        quot = ({64'd0, mag} << FRAC_BITS) / {64'd0, w};
        bound = neg ? SAT_POS + 1 : SAT_POS;
        if (quot > {64'd0, bound})
        begin
            sat_seen = 1'b1;
            quot = {64'd0, bound};
        end
        return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
    endfunction

    function automatic spline_result_t predict_spline(logic [VAL_W-1:0] position);
        spline_result_t res;
        int             k;
        longint         v;
        k = (num_dirs_reg > MAX_DIRECTIONS) ? MAX_DIRECTIONS : int'(num_dirs_reg);
        sat_seen = 1'b0;
        v = centred_difference(0, k, longint'($signed(position)), int'($signed(order_ofs_reg)));
        res.value = v[VAL_W-1:0];
        res.flag = sat_seen;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        spline_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.value)
                    report_mismatch($sformatf("spline_value %h expected %h",
                                              m_tdata, exp_res.value));
                if (m_tuser !== exp_res.flag)
                    report_mismatch($sformatf("overflow_flag %b expected %b",
                                              m_tuser, exp_res.flag));
            end
        end
    end

    // receiver stalls, mostly short
    always @(negedge clk)
    begin
        int pick;
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                m_tready <= 1'b1;
            else
            begin
                ready_hold = (pick < 97) ? $urandom_range(0, 3) : $urandom_range(20, 200);
                m_tready <= 1'b0;
            end
        end
    end

    task automatic send_position(logic [VAL_W-1:0] position);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap = (pick < 50) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 100);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = position;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_spline(position));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WID_W-1:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_wr_en = 1'b1;
        case (idx)
            REG_NUM_DIRS:    num_dirs_reg = value[2:0];
            REG_WIDTH_ZERO:  width_reg[0] = value;
            REG_WIDTH_ONE:   width_reg[1] = value;
            REG_WIDTH_TWO:   width_reg[2] = value;
            REG_WIDTH_THREE: width_reg[3] = value;
            REG_ORDER_OFS:   order_ofs_reg = value[2:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(logic [2:0] dirs, logic [WID_W-1:0] w0, logic [WID_W-1:0] w1,
                              logic [WID_W-1:0] w2, logic [WID_W-1:0] w3, logic [2:0] ofs);
        wait_drained();
        write_reg(REG_NUM_DIRS, WID_W'(dirs));
        write_reg(REG_WIDTH_ZERO, w0);
        write_reg(REG_WIDTH_ONE, w1);
        write_reg(REG_WIDTH_TWO, w2);
        write_reg(REG_WIDTH_THREE, w3);
        write_reg(REG_ORDER_OFS, WID_W'(ofs));
    endtask

    function automatic logic [VAL_W-1:0] random_position();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return VAL_W'({$urandom(), $urandom()});
        if (pick < 8)
            return VAL_W'($signed(36'($urandom_range(0, 32'hFFFF_FFFF)) - 36'h8_0000_0000
                                  + 36'({$urandom_range(0, 15), 32'd0})));
        return VAL_W'($signed(35'({$urandom(), $urandom()})));
    endfunction

    function automatic logic [WID_W-1:0] random_width();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return WIDTH_MAX;
            2:       return WID_W'($urandom_range(1, 7));
            3:       return WID_W'({$urandom(), $urandom()});
            default: return WID_W'({$urandom_range(0, 3), $urandom()});
        endcase
    endfunction

    task automatic test_reset_step();
        send_position('0);
        send_position('1);
        send_position({VAL_W{1'b1}});
        send_position(VAL_MAX);
        send_position(~VAL_MAX);
    endtask

    task automatic test_directed_cases();
        // a width of 2^40, both ends of the position range
        set_config(3'd1, WIDTH_MAX, '0, '0, '0, 3'd0);
        send_position(VAL_MAX);
        send_position(~VAL_MAX);
        send_position(VAL_ONE);
        // odd widths truncate the half step
        set_config(3'd2, 41'd1, 41'd3, '0, '0, 3'd0);
        send_position('0);
        send_position(VAL_W'(1));
        // divide by width saturates
        set_config(3'd1, 41'd2, '0, '0, '0, 3'b111);
        send_position('0);
        send_position({VAL_W{1'b1}});
        // too many directions, a zero width skipped, high leaf order
        set_config(3'd7, {9'd0, VAL_ONE[31:0]}, '0, 41'h2_0000_0000, 41'h3_8000_0000, 3'd3);
        send_position(VAL_ONE);
        send_position(VAL_MAX);
        // negative leaf order gives zero
        set_config(3'd2, 41'h1_0000_0000, 41'h1_0000_0000, '0, '0, 3'b100);
        send_position('0);
        send_position(VAL_ONE);
        // power loop saturates
        set_config(3'd0, '0, '0, '0, '0, 3'd3);
        send_position(VAL_MAX);
        send_position(VAL_ONE);
    endtask

    task automatic test_random_settings();
        int dirs;
        int active;
        int count;
        while (items_sent < 500)
        begin
            dirs = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            set_config(3'(dirs), random_width(), random_width(), random_width(),
                       random_width(), 3'($urandom_range(0, 7)));
            active = 0;
            for (int i = 0; i < 4 && i < dirs; i++)
                if (width_reg[i] != 0)
                    active++;
            count = (active >= 3) ? 4 : $urandom_range(15, 40);
            for (int i = 0; i < count; i++)
            begin
                send_position(random_position());
                if (i == count / 2 && $urandom_range(0, 3) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_step();
        test_directed_cases();
        test_random_settings();
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hdl/bse_pkg.sv
hdl/bse_div.sv
hdl/bse_dpath.sv
hdl/bse_ctrl.sv
hdl/box_spline_evaluation.sv
hdl/bse_checker.sv
dv/tb_box_spline_evaluation.sv
